// ===== hw/rtl/lpd_pkg.sv =====
package lpd_pkg;

    // Header layout: 4-byte little-endian total length, 4-byte big-endian id
    localparam int unsigned HDR_BYTES = 8;
    localparam int unsigned HDR_CNT_W = 3;

    localparam int unsigned ID_W  = 32;
    localparam int unsigned LEN_W = 31;

    // Configuration register indexes
    localparam logic [1:0] CFG_COMPRESS_EN   = 2'd0;
    localparam logic [1:0] CFG_COMPRESS_MASK = 2'd1;
    localparam logic [1:0] CFG_MAX_LEN       = 2'd2;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_LEN_ERR = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [ID_W-1:0]   id;
        logic [7:0]        data;
        logic [LEN_W-1:0]  len;
        logic              last;
    } t_result;

endpackage

// ===== hw/rtl/lpd_out_buf.sv =====
// Two-entry result buffer; keeps the processing stage moving while the
// receiver stalls, until both entries are full.
module lpd_out_buf import lpd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    t_result    r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    logic       pop;
    logic [1:0] n_count;

    assign o_valid = (r_count != 2'd0);
    assign pop     = o_valid && i_ready;
    assign o_space = (r_count != 2'd2) || pop;
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && r_count == 2'd2) |-> pop)
        else $error("push into full result buffer");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result buffer count out of range");

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd1) |-> (r_wptr != r_rptr))
        else $error("result buffer pointers disagree with count");

endmodule

// ===== hw/rtl/length_prefixed_message_deframer.sv =====
// Length-prefixed message deframer.
//
// Input channel (i_valid / o_ready / i_in_byte) carries the received stream,
// one byte per word. Each message starts with an 8-byte header: a 32-bit
// little-endian total length (header included), then a 32-bit big-endian id.
// Output channel (o_valid / i_ready) gives one word per payload byte with the
// message id and payload length; the final byte has o_last_of_message set.
// A zero-length message gives a single KIND_EMPTY word. A length that is
// negative or above max_payload_length gives one KIND_LEN_ERR word and the
// block then swallows every further byte until reset.
//
// Timing: one byte per clock sustained while the result buffer has space.
// A byte lands in the input register at acceptance and is decoded into a
// two-entry result buffer once it has space; o_valid comes from that buffer.
// When the receiver stalls the buffer absorbs up to two results; after that
// the input register holds and o_ready drops until a word is taken.
// Reset (synchronous, active low) restarts header collection, clears the
// halt and restores the register defaults: compression off, mask 0x80000000,
// max payload length 8192. Config writes are taken at any edge with i_cfg_we.
module length_prefixed_message_deframer import lpd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // config write port
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_wdata,
    // byte stream in
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_in_byte,
    // results out
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_result_kind,
    output logic [ID_W-1:0]   o_message_id,
    output logic [7:0]        o_payload_byte,
    output logic [LEN_W-1:0]  o_message_length,
    output logic              o_last_of_message
);

    typedef enum logic [2:0] {
        PH_HDR  = 3'b001,
        PH_PAY  = 3'b010,
        PH_HALT = 3'b100
    } t_phase;

    // config registers
    logic             r_comp_en;
    logic [31:0]      r_comp_mask;
    logic [LEN_W-1:0] r_max_len;

    // input register
    logic             r_in_valid;
    logic [7:0]       r_in_byte;

    // framing state
    t_phase               r_phase,   n_phase;
    logic [HDR_CNT_W-1:0] r_hdr_cnt, n_hdr_cnt;
    logic [55:0]          r_hdr,     n_hdr;      // header bytes 0..6, byte 0 lowest
    logic [ID_W-1:0]      r_id,      n_id;
    logic [LEN_W-1:0]     r_len,     n_len;
    logic [LEN_W-1:0]     r_remain,  n_remain;

    // decode stage
    logic        go;
    logic        buf_space;
    logic        res_push;
    t_result     res;
    t_result     out_word;

    logic [31:0]     hdr_total;
    logic [ID_W-1:0] hdr_id;
    logic [31:0]     pay_len;
    logic            len_bad;

    assign go      = r_in_valid && buf_space;
    assign o_ready = !r_in_valid || buf_space;

    // Header fields as they stand when the eighth byte is in r_in_byte
    assign hdr_total = r_hdr[31:0];
    assign hdr_id    = {r_hdr[39:32], r_hdr[47:40], r_hdr[55:48], r_in_byte};

    always_comb begin
        pay_len = hdr_total - 32'(HDR_BYTES);
        if (r_comp_en) begin
            pay_len = pay_len & ~r_comp_mask;
        end
    end

    // negative as signed 32, or above the limit
    assign len_bad = pay_len[31] || (pay_len[LEN_W-1:0] > r_max_len);

    always_comb begin
        n_phase   = r_phase;
        n_hdr_cnt = r_hdr_cnt;
        n_hdr     = r_hdr;
        n_id      = r_id;
        n_len     = r_len;
        n_remain  = r_remain;
        res_push  = 1'b0;
        res.kind  = KIND_PAYLOAD;
        res.id    = r_id;
        res.data  = r_in_byte;
        res.len   = r_len;
        res.last  = 1'b0;

        if (go) begin
            unique case (r_phase)
                PH_HDR: begin
                    if (r_hdr_cnt != HDR_CNT_W'(HDR_BYTES - 1)) begin
                        n_hdr     = {r_in_byte, r_hdr[55:8]};
                        n_hdr_cnt = r_hdr_cnt + HDR_CNT_W'(1);
                    end else begin
                        n_hdr_cnt = '0;
                        n_id      = hdr_id;
                        n_len     = pay_len[LEN_W-1:0];
                        res.id    = hdr_id;
                        res.data  = 8'd0;
                        res.len   = pay_len[LEN_W-1:0];
                        if (len_bad) begin
                            n_phase  = PH_HALT;
                            n_remain = '0;
                            res_push = 1'b1;
                            res.kind = KIND_LEN_ERR;
                        end else if (pay_len == 32'd0) begin
                            n_remain = '0;
                            res_push = 1'b1;
                            res.kind = KIND_EMPTY;
                            res.last = 1'b1;
                        end else begin
                            n_remain = pay_len[LEN_W-1:0];
                            n_phase  = PH_PAY;
                        end
                    end
                end
                PH_PAY: begin
                    res_push = 1'b1;
                    res.last = (r_remain <= LEN_W'(1));
                    if (res.last) begin
                        n_remain = '0;
                        n_phase  = PH_HDR;
                    end else begin
                        n_remain = r_remain - LEN_W'(1);
                    end
                end
                default: begin
                    // halted: byte is consumed and dropped
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comp_en   <= 1'b0;
            r_comp_mask <= 32'h8000_0000;
            r_max_len   <= LEN_W'(8192);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_COMPRESS_EN:   r_comp_en   <= i_cfg_wdata[0];
                CFG_COMPRESS_MASK: r_comp_mask <= i_cfg_wdata;
                CFG_MAX_LEN:       r_max_len   <= i_cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_HDR;
            r_hdr_cnt  <= '0;
            r_id       <= '0;
            r_len      <= '0;
            r_remain   <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_id      <= n_id;
            r_len     <= n_len;
            r_remain  <= n_remain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_in_byte;
        end
        r_hdr <= n_hdr;
    end

    lpd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_space (buf_space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (out_word)
    );

    assign o_result_kind     = out_word.kind;
    assign o_message_id      = out_word.id;
    assign o_payload_byte    = out_word.data;
    assign o_message_length  = out_word.len;
    assign o_last_of_message = out_word.last;

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HALT) |=> (r_phase == PH_HALT))
        else $error("left halt without reset");

    a_pay_remain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAY) |-> (r_remain != '0))
        else $error("payload phase with nothing remaining");

    a_hdr_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_HDR) |-> (r_hdr_cnt == '0))
        else $error("header count nonzero outside header phase");

endmodule
